// ===== rtl/tws_pkg.sv =====
// shared constants, types and helper functions for the tachometer with digit scan
`default_nettype none

package tws_pkg;

    localparam int COUNT_BITS = 12;
    localparam int NUM_DIGITS = 4;
    localparam int RATE_W     = 20;
    localparam int SCALE_W    = 8;
    localparam int TICK_W     = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int IDX_W      = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam int PROD_W     = COUNT_BITS + SCALE_W;
    localparam int CMP_W      = (PROD_W > RATE_W) ? PROD_W : RATE_W;

    // register indexes of the configuration port
    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_SCALE  = CFG_ADDR_W'(1);
    localparam logic [CFG_ADDR_W-1:0] REG_DWELL  = CFG_ADDR_W'(2);

    localparam logic [TICK_W-1:0]     WINDOW_RESET = TICK_W'(1000);
    localparam logic [TICK_W-1:0]     DWELL_RESET  = TICK_W'(50);
    localparam logic [SCALE_W-1:0]    SCALE_RESET  = SCALE_W'(60);
    localparam logic [RATE_W-1:0]     RATE_RESET   = RATE_W'(1234);
    localparam logic [RATE_W-1:0]     RATE_MAX     = {RATE_W{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_MAX    = {COUNT_BITS{1'b1}};

    // x / 10 == (x * 838861) >> 23, exact for any 20 bit x
    localparam logic [RATE_W-1:0] DIV10_MUL   = RATE_W'(838861);
    localparam int                DIV10_SHIFT = 23;

    typedef logic [NUM_DIGITS-1:0][3:0] digits_t;

    typedef struct packed {
        logic                  we;
        logic [CFG_ADDR_W-1:0] addr;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

    // one item after the counter stage
    typedef struct packed {
        logic                  close;
        logic [COUNT_BITS-1:0] count;
        logic                  wrap;
        logic [IDX_W-1:0]      idx;
    } cnt_item_t;

    // one item in the rate and digit stages
    typedef struct packed {
        logic [RATE_W-1:0] rate;
        logic [RATE_W-1:0] quot;
        logic              wrap;
        logic [IDX_W-1:0]  idx;
        digits_t           digits;
    } item_t;

    function automatic logic [RATE_W-1:0] div10_f(input logic [RATE_W-1:0] v);
        logic [2*RATE_W-1:0] p;
        p = (2*RATE_W)'(v) * (2*RATE_W)'(DIV10_MUL);
        return RATE_W'(p >> DIV10_SHIFT);
    endfunction

    function automatic logic [3:0] rem10_f(input logic [RATE_W-1:0] v,
                                           input logic [RATE_W-1:0] q);
        logic [RATE_W-1:0] r;
        r = v - (q << 3) - (q << 1);
        return r[3:0];
    endfunction

    function automatic digits_t reset_digits_f();
        digits_t           d;
        logic [RATE_W-1:0] v;
        logic [RATE_W-1:0] q;
        v = RATE_RESET;
        for (int k = 0; k < NUM_DIGITS; k++)
        begin
            q    = div10_f(v);
            d[k] = rem10_f(v, q);
            v    = q;
        end
        return d;
    endfunction

    localparam digits_t RESET_DIGITS = reset_digits_f();

    // scan index as the 2 bit output field
    function automatic logic [1:0] idx_field_f(input logic [IDX_W-1:0] i);
        logic [IDX_W+1:0] w;
        w = (IDX_W+2)'(i);
        return w[1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tws_gate_scan.sv =====
// pulse, gate and scan counters: first pipeline stage of the tachometer
`default_nettype none

module tws_gate_scan
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire tws_pkg::cfg_wr_t   cfg,
    input  wire logic               adv,
    input  wire logic               accept,
    input  wire logic               pulse,
    input  wire logic               gate_tick,
    input  wire logic               scan_tick,
    output tws_pkg::cnt_item_t      item,
    output logic                    item_valid
);
    import tws_pkg::*;

    logic [TICK_W-1:0]     window_reg;
    logic [TICK_W-1:0]     dwell_reg;
    logic [COUNT_BITS-1:0] pulse_count_reg;
    logic [COUNT_BITS-1:0] pulse_count_next;
    logic [TICK_W-1:0]     gate_count_reg;
    logic [TICK_W-1:0]     gate_count_next;
    logic [TICK_W-1:0]     dwell_count_reg;
    logic [TICK_W-1:0]     dwell_count_next;
    logic [IDX_W-1:0]      scan_index_reg;
    logic [IDX_W-1:0]      scan_index_next;
    cnt_item_t             item_reg;
    cnt_item_t             item_next;
    logic                  item_valid_reg;

    logic [COUNT_BITS-1:0] pulse_inc;
    logic [TICK_W:0]       gate_inc;
    logic [TICK_W:0]       dwell_inc;
    logic [IDX_W:0]        index_inc;
    logic                  close;
    logic                  step;
    logic                  wrap;

    always_comb
    begin
        pulse_inc = (pulse && pulse_count_reg != COUNT_MAX) ?
                    pulse_count_reg + COUNT_BITS'(1) : pulse_count_reg;
        gate_inc  = (TICK_W+1)'(gate_count_reg) + (TICK_W+1)'(1);
        dwell_inc = (TICK_W+1)'(dwell_count_reg) + (TICK_W+1)'(1);
        index_inc = (IDX_W+1)'(scan_index_reg) + (IDX_W+1)'(1);

        // zero in a tick register acts as one
        close = gate_tick && (gate_inc >= (TICK_W+1)'(window_reg));
        step  = scan_tick && (dwell_inc >= (TICK_W+1)'(dwell_reg));
        wrap  = step && (index_inc >= (IDX_W+1)'(NUM_DIGITS));

        pulse_count_next = close ? '0 : pulse_inc;
        gate_count_next  = gate_count_reg;
        if (gate_tick)
        begin
            gate_count_next = close ? '0 : gate_inc[TICK_W-1:0];
        end
        dwell_count_next = dwell_count_reg;
        if (scan_tick)
        begin
            dwell_count_next = step ? '0 : dwell_inc[TICK_W-1:0];
        end
        scan_index_next = scan_index_reg;
        if (step)
        begin
            scan_index_next = wrap ? '0 : index_inc[IDX_W-1:0];
        end

        item_next.close = close;
        item_next.count = pulse_inc;
        item_next.wrap  = wrap;
        item_next.idx   = scan_index_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg      <= WINDOW_RESET;
            dwell_reg       <= DWELL_RESET;
            pulse_count_reg <= '0;
            gate_count_reg  <= '0;
            dwell_count_reg <= '0;
            scan_index_reg  <= '0;
            item_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg.we && cfg.addr == REG_WINDOW)
            begin
                window_reg <= cfg.data[TICK_W-1:0];
            end
            if (cfg.we && cfg.addr == REG_DWELL)
            begin
                dwell_reg <= cfg.data[TICK_W-1:0];
            end
            if (accept)
            begin
                pulse_count_reg <= pulse_count_next;
                gate_count_reg  <= gate_count_next;
                dwell_count_reg <= dwell_count_next;
                scan_index_reg  <= scan_index_next;
            end
            if (adv)
            begin
                item_valid_reg <= accept;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

    assign item       = item_reg;
    assign item_valid = item_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/tws_rate.sv =====
// window rate: pulse count times scale, saturated, held between windows
`default_nettype none

module tws_rate
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire tws_pkg::cfg_wr_t   cfg,
    input  wire logic               adv,
    input  wire tws_pkg::cnt_item_t in_item,
    input  wire logic               in_valid,
    output tws_pkg::item_t          out_item,
    output logic                    out_valid
);
    import tws_pkg::*;

    logic [SCALE_W-1:0] scale_reg;
    logic [RATE_W-1:0]  rate_reg;
    logic [RATE_W-1:0]  rate_next;
    item_t              item_reg;
    item_t              item_next;
    logic               valid_reg;

    logic [PROD_W-1:0]  prod;
    logic [CMP_W-1:0]   prod_cmp;

    always_comb
    begin
        prod     = PROD_W'(in_item.count) * PROD_W'(scale_reg);
        prod_cmp = CMP_W'(prod);
        rate_next = rate_reg;
        if (in_item.close)
        begin
            rate_next = (prod_cmp > CMP_W'(RATE_MAX)) ? RATE_MAX : prod_cmp[RATE_W-1:0];
        end
        item_next.rate   = rate_next;
        item_next.quot   = rate_next;
        item_next.wrap   = in_item.wrap;
        item_next.idx    = in_item.idx;
        item_next.digits = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SCALE_RESET;
            rate_reg  <= RATE_RESET;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.we && cfg.addr == REG_SCALE)
            begin
                scale_reg <= cfg.data[SCALE_W-1:0];
            end
            if (adv)
            begin
                valid_reg <= in_valid;
                if (in_valid)
                begin
                    rate_reg <= rate_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_valid)
        begin
            item_reg <= item_next;
        end
    end

    assign out_item  = item_reg;
    assign out_valid = valid_reg;

endmodule

`default_nettype wire

// ===== rtl/tws_digit_stage.sv =====
// one decimal digit per stage: splits off value mod 10 and passes value / 10 on
`default_nettype none

module tws_digit_stage
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           adv,
    input  wire tws_pkg::item_t in_item,
    input  wire logic           in_valid,
    output tws_pkg::item_t      out_item,
    output logic                out_valid
);
    import tws_pkg::*;

    item_t             item_reg;
    item_t             item_next;
    logic              valid_reg;
    logic [RATE_W-1:0] quot;
    logic [3:0]        digit;

    always_comb
    begin
        quot  = div10_f(in_item.quot);
        digit = rem10_f(in_item.quot, quot);
        item_next      = in_item;
        item_next.quot = quot;
        // new digit enters at the top, the lowest digit lands at index 0 after the last stage
        item_next.digits = in_item.digits >> 4;
        item_next.digits[NUM_DIGITS-1] = digit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_valid)
        begin
            item_reg <= item_next;
        end
    end

    assign out_item  = item_reg;
    assign out_valid = valid_reg;

endmodule

`default_nettype wire

// ===== rtl/tachometer_with_digit_scan_top.sv =====
// top level: counter, rate and digit stages, digit latch and result register
//
//   channel  direction  signals                       contents
//   s_axis   in         s_tvalid s_tready s_tdata[7:0] pulse, gate_tick, scan_tick
//   m_axis   out        m_tvalid m_tready m_tdata[31:0] rate, digit_index, digit_value
//   cfg      in         cfg_we cfg_addr cfg_wdata      window_ticks, scale, dwell_ticks
//
// one transaction in per clock while no result is held; each result passes through the registers
// (counter stage, rate multiply stage, one stage per decimal digit, result register)
// reset loads window 1000, scale 60, dwell 50, rate 1234 and its digits; no clearing pass
// a held result stalls every stage at once, s_tready follows !m_tvalid || m_tready
`default_nettype none

module tachometer_with_digit_scan_top
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [7:0]                        s_tdata,   // pulse, gate_tick, scan_tick, pad
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [31:0]                            m_tdata,   // rate, digit_index, digit_value, pad
    input  wire logic                              cfg_we,
    input  wire logic [tws_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [tws_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import tws_pkg::*;

    cfg_wr_t           cfg;
    logic              adv;
    logic              accept;
    cnt_item_t         cnt_item;
    logic              cnt_valid;
    item_t             stage_item [NUM_DIGITS+1];
    logic [NUM_DIGITS:0] stage_valid;

    item_t             last_item;
    logic              last_valid;
    digits_t           shown;
    digits_t           latched_reg;
    logic              out_valid_reg;
    logic [RATE_W-1:0] rate_out_reg;
    logic [1:0]        idx_out_reg;
    logic [3:0]        digit_out_reg;

    assign cfg.we   = cfg_we;
    assign cfg.addr = cfg_addr;
    assign cfg.data = cfg_wdata;

    assign adv      = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && adv;
    assign s_tready = adv;

    tws_gate_scan u_gate_scan
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .adv        (adv),
        .accept     (accept),
        .pulse      (s_tdata[0]),
        .gate_tick  (s_tdata[1]),
        .scan_tick  (s_tdata[2]),
        .item       (cnt_item),
        .item_valid (cnt_valid)
    );

    tws_rate u_rate
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .adv       (adv),
        .in_item   (cnt_item),
        .in_valid  (cnt_valid),
        .out_item  (stage_item[0]),
        .out_valid (stage_valid[0])
    );

    for (genvar k = 0; k < NUM_DIGITS; k++)
    begin : g_digit
        tws_digit_stage u_digit
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_item   (stage_item[k]),
            .in_valid  (stage_valid[k]),
            .out_item  (stage_item[k+1]),
            .out_valid (stage_valid[k+1])
        );
    end

    assign last_item  = stage_item[NUM_DIGITS];
    assign last_valid = stage_valid[NUM_DIGITS];

    // a wrapping item shows the digits it latches
    assign shown = last_item.wrap ? last_item.digits : latched_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latched_reg   <= RESET_DIGITS;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= last_valid;
            if (last_valid && last_item.wrap)
            begin
                latched_reg <= last_item.digits;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && last_valid)
        begin
            rate_out_reg  <= last_item.rate;
            idx_out_reg   <= idx_field_f(last_item.idx);
            digit_out_reg <= shown[last_item.idx];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, digit_out_reg, idx_out_reg, rate_out_reg};

    a_digit_decimal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> digit_out_reg <= 4'd9)
        else $error("result digit is not a decimal digit");

    a_wrap_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        last_valid && last_item.wrap |-> last_item.idx == '0)
        else $error("digit latch with scan index not at digit 0");

    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(stage_valid) && $stable(cnt_valid))
        else $error("pipeline moved while the result was held");

    a_latch_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !(adv && last_valid && last_item.wrap) |=> $stable(latched_reg))
        else $error("latched digits changed without a scan wrap");

endmodule

`default_nettype wire

// ===== bench/tb_tachometer_with_digit_scan_top.sv =====
// self-checking testbench for the tachometer with digit scan: directed table, then random phases
`default_nettype none

module tb_tachometer_with_digit_scan_top;

    import tws_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 20;
    localparam int PHASES         = 10;
    localparam int PHASE_ITEMS    = 170;
    localparam int FILL_ITEMS     = 220;
    localparam int FILL_PHASE     = 5;

    typedef struct {
        logic [RATE_W-1:0] rate;
        logic [1:0]        idx;
        logic [3:0]        digit;
    } reading_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic                  pulse;
        logic                  gate;
        logic                  scan;
        bit                    typed;
        reading_t              want;
        logic [CFG_ADDR_W-1:0] addr;
        logic [CFG_DATA_W-1:0] data;
    } plan_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;    // pulse, gate_tick, scan_tick, pad
    logic                  m_tvalid;
    logic                  m_tready;
    logic [31:0]           m_tdata;    // rate, digit_index, digit_value, pad
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    bit       idle_en;
    int       stall_left;
    int       mismatches;
    int       quiet_cycles;
    reading_t pending_readings[$];

    // tachometer state as the block should hold it
    logic [TICK_W-1:0]     win_cfg;
    logic [SCALE_W-1:0]    scale_cfg;
    logic [TICK_W-1:0]     dwell_cfg;
    logic [COUNT_BITS-1:0] pulse_cnt;
    logic [TICK_W-1:0]     gate_cnt;
    logic [RATE_W-1:0]     rate_q;
    int                    scan_pos;
    logic [TICK_W-1:0]     dwell_cnt;
    logic [3:0]            shown [NUM_DIGITS];

    tachometer_with_digit_scan_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    task automatic latch_shown(input int v);
        int rest;
        rest = v;
        for (int k = 0; k < NUM_DIGITS; k++)
        begin
            shown[k] = 4'(rest % 10);
            rest     = rest / 10;
        end
    endtask

    task automatic reset_tach();
        win_cfg   = WINDOW_RESET;
        scale_cfg = SCALE_RESET;
        dwell_cfg = DWELL_RESET;
        pulse_cnt = '0;
        gate_cnt  = '0;
        rate_q    = RATE_RESET;
        scan_pos  = 0;
        dwell_cnt = '0;
        latch_shown(int'(RATE_RESET));
    endtask

    // pulse first, then the gate tick, then the scan tick
    task automatic advance_tach(input logic p, input logic g, input logic s,
                                output reading_t r);
        int nxt;
        int prod;
        if (p && pulse_cnt != COUNT_MAX)
            pulse_cnt = pulse_cnt + 1'b1;
        if (g)
        begin
            nxt = int'(gate_cnt) + 1;
            if (nxt >= int'(win_cfg))
            begin
                prod      = int'(pulse_cnt) * int'(scale_cfg);
                rate_q    = (prod > int'(RATE_MAX)) ? RATE_MAX : RATE_W'(prod);
                pulse_cnt = '0;
                gate_cnt  = '0;
            end
            else
                gate_cnt = TICK_W'(nxt);
        end
        if (s)
        begin
            nxt = int'(dwell_cnt) + 1;
            if (nxt >= int'(dwell_cfg))
            begin
                dwell_cnt = '0;
                scan_pos  = scan_pos + 1;
                if (scan_pos >= NUM_DIGITS)
                begin
                    scan_pos = 0;
                    latch_shown(int'(rate_q));
                end
            end
            else
                dwell_cnt = TICK_W'(nxt);
        end
        r.rate  = rate_q;
        r.idx   = 2'(scan_pos);
        r.digit = shown[scan_pos % NUM_DIGITS];
    endtask

    // called and returns at a rising edge; returns at the edge that takes the transaction
    task automatic feed_item(input logic p, input logic g, input logic s);
        reading_t r;
        if (idle_en && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, s, g, p};
        @(negedge clk);
        while (!s_tready)
            @(negedge clk);
        @(posedge clk);
        advance_tach(p, g, s, r);
        pending_readings.push_back(r);
    endtask

    task automatic await_drain();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending_readings.size() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (addr)
            REG_WINDOW: win_cfg   = data;
            REG_SCALE:  scale_cfg = data[SCALE_W-1:0];
            REG_DWELL:  dwell_cfg = data;
            default: ;
        endcase
        @(posedge clk);
    endtask

    function automatic plan_row_t item_row(input logic p, input logic g, input logic s,
                                           input bit typed = 1'b0, input int rate = 0,
                                           input int idx = 0, input int digit = 0);
        plan_row_t row;
        row.kind       = ROW_ITEM;
        row.pulse      = p;
        row.gate       = g;
        row.scan       = s;
        row.typed      = typed;
        row.want.rate  = RATE_W'(rate);
        row.want.idx   = 2'(idx);
        row.want.digit = 4'(digit);
        row.addr       = REG_WINDOW;
        row.data       = '0;
        return row;
    endfunction

    function automatic plan_row_t cfg_row(input logic [CFG_ADDR_W-1:0] addr,
                                          input logic [CFG_DATA_W-1:0] data);
        plan_row_t row;
        row       = item_row(1'b0, 1'b0, 1'b0);
        row.kind  = ROW_CFG;
        row.addr  = addr;
        row.data  = data;
        return row;
    endfunction

    // receiver: random stall bursts while idling is on
    always @(posedge clk)
    begin
        if (!idle_en)
        begin
            stall_left = 0;
            m_tready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 5);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // signals are stable at the falling edge; a transaction seen here completes at the next rise
    always @(negedge clk)
    begin : result_check
        reading_t got;
        reading_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.rate  = m_tdata[RATE_W-1:0];
                got.idx   = m_tdata[RATE_W+1:RATE_W];
                got.digit = m_tdata[RATE_W+5:RATE_W+2];
                if (pending_readings.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result, rate %0d digit_index %0d digit_value %0d",
                             $time, got.rate, got.idx, got.digit);
                end
                else
                begin
                    want = pending_readings.pop_front();
                    if (got.rate !== want.rate)
                    begin
                        mismatches++;
                        $display("%0t: rate expected %0d actual %0d",
                                 $time, want.rate, got.rate);
                    end
                    if (got.idx !== want.idx)
                    begin
                        mismatches++;
                        $display("%0t: digit_index expected %0d actual %0d",
                                 $time, want.idx, got.idx);
                    end
                    if (got.digit !== want.digit)
                    begin
                        mismatches++;
                        $display("%0t: digit_value expected %0d actual %0d",
                                 $time, want.digit, got.digit);
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        plan_row_t         plan[$];
        logic [TICK_W-1:0] win_sel;
        logic [TICK_W-1:0] dwell_sel;
        logic [7:0]        scale_sel;
        int                pulse_pct;

        clk          = 1'b0;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b1;
        cfg_we       = 1'b0;
        cfg_addr     = REG_WINDOW;
        cfg_wdata    = '0;
        idle_en      = 1'b1;
        stall_left   = 0;
        mismatches   = 0;
        quiet_cycles = 0;
        reset_tach();

        // reset values first, then zero window and dwell, extreme scales, lowered settings
        plan.push_back(item_row(1'b0, 1'b0, 1'b0, 1'b1, 1234, 0, 4));
        plan.push_back(item_row(1'b1, 1'b0, 1'b1, 1'b1, 1234, 0, 4));
        plan.push_back(cfg_row(REG_WINDOW, 16'd0));
        plan.push_back(cfg_row(REG_DWELL, 16'd0));
        plan.push_back(cfg_row(REG_SCALE, 16'd255));
        plan.push_back(item_row(1'b1, 1'b1, 1'b0, 1'b1, 510, 0, 4));
        plan.push_back(item_row(1'b0, 1'b0, 1'b1, 1'b1, 510, 1, 3));
        plan.push_back(item_row(1'b0, 1'b0, 1'b1, 1'b1, 510, 2, 2));
        plan.push_back(item_row(1'b0, 1'b0, 1'b1, 1'b1, 510, 3, 1));
        plan.push_back(item_row(1'b0, 1'b0, 1'b1, 1'b1, 510, 0, 0));
        plan.push_back(item_row(1'b1, 1'b1, 1'b1, 1'b1, 255, 1, 1));
        plan.push_back(cfg_row(REG_SCALE, 16'd0));
        plan.push_back(item_row(1'b1, 1'b1, 1'b0, 1'b1, 0, 1, 1));
        plan.push_back(cfg_row(REG_SCALE, 16'hFF01));    // upper byte is ignored
        plan.push_back(cfg_row(REG_WINDOW, 16'hFFFF));
        plan.push_back(cfg_row(REG_DWELL, 16'hFFFF));
        plan.push_back(item_row(1'b1, 1'b0, 1'b0));
        plan.push_back(item_row(1'b1, 1'b1, 1'b0));
        plan.push_back(item_row(1'b0, 1'b1, 1'b1));
        plan.push_back(cfg_row(REG_WINDOW, 16'd1));
        plan.push_back(item_row(1'b1, 1'b1, 1'b0));
        plan.push_back(cfg_row(REG_DWELL, 16'd1));
        plan.push_back(item_row(1'b0, 1'b0, 1'b1));
        plan.push_back(item_row(1'b1, 1'b1, 1'b1));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
            begin
                await_drain();
                write_reg(plan[i].addr, plan[i].data);
            end
            else
            begin
                feed_item(plan[i].pulse, plan[i].gate, plan[i].scan);
                if (plan[i].typed)
                    pending_readings[pending_readings.size()-1] = plan[i].want;
            end
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            await_drain();
            idle_en <= (ph % 3 != 2) && (ph != PHASES - 1);
            case (ph)
                0:       win_sel = 16'd1;
                1:       win_sel = 16'd0;
                2:       win_sel = TICK_W'($urandom_range(2, 12));
                3:       win_sel = 16'hFFFF;
                default: win_sel = TICK_W'($urandom_range(1, 16));
            endcase
            case (ph)
                0:       scale_sel = 8'd255;
                2:       scale_sel = 8'd1;
                4:       scale_sel = 8'd0;
                5:       scale_sel = 8'd255;
                default: scale_sel = 8'($urandom_range(1, 255));
            endcase
            case (ph)
                0:       dwell_sel = 16'd1;
                2:       dwell_sel = 16'd0;
                4:       dwell_sel = 16'hFFFF;
                default: dwell_sel = TICK_W'($urandom_range(0, 5));
            endcase
            write_reg(REG_WINDOW, win_sel);
            write_reg(REG_SCALE, {8'($urandom), scale_sel});
            write_reg(REG_DWELL, dwell_sel);

            pulse_pct = $urandom_range(20, 95);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if ($urandom_range(0, 99) == 0)
                    await_drain();
                feed_item($urandom_range(0, 99) < pulse_pct, $urandom_range(0, 2) == 0,
                          1'($urandom_range(0, 1)));
            end

            if (ph == FILL_PHASE)
            begin
                // a long window with a pulse in every transaction, then scan out its rate
                await_drain();
                write_reg(REG_WINDOW, 16'd1);
                write_reg(REG_SCALE, {8'($urandom), 8'd255});
                write_reg(REG_DWELL, 16'd1);
                for (int i = 0; i < FILL_ITEMS; i++)
                    feed_item(1'b1, 1'b0, 1'($urandom_range(0, 1)));
                feed_item(1'b1, 1'b1, 1'b0);
                for (int i = 0; i < 2 * NUM_DIGITS; i++)
                    feed_item(1'b0, 1'b0, 1'b1);
            end
        end

        await_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_readings.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
